FILE: hw/rtl/h4rx_pkg.sv
`default_nettype none

package h4rx_pkg;

  // Header and result sizing
  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned MAX_RESULTS = 4;

  // Packet type bytes
  localparam logic [7:0] TYPE_EVT = 8'h04;
  localparam logic [7:0] TYPE_ACL = 8'h02;

  // Event codes of interest
  localparam logic [7:0] EVT_LE_META   = 8'h3E;
  localparam logic [7:0] LE_ADV_REPORT = 8'h02;
  localparam logic [7:0] EVT_INQ_RSSI  = 8'h22;
  localparam logic [7:0] EVT_INQ_EXT   = 8'h2F;

  // Result status codes
  localparam logic [1:0] ST_BYTE     = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PAYLOAD_LIMIT = 1'b0;
  localparam logic CFG_BREDR_ENABLE  = 1'b1;

  // One result word
  typedef struct packed {
    logic [1:0] status;
    logic       drop_ok;
    logic       last_flag;
    logic       first_flag;
    logic       packet_kind;
    logic [7:0] out_byte;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hci_h4_receive_deframer.sv
// Latency: results of an accepted byte are offered from the next cycle.
// Throughput: one byte per cycle for type, header and payload bytes unless
// the output stalls; a byte that completes a header yields up to four words
// (header bytes); the result buffer holds input off till the last is taken.
// Reset (rst, synchronous, active high): back to waiting for a type byte,
// result buffer empty, payload_limit = 255, bredr_enable = 0.
`default_nettype none

module hci_h4_receive_deframer
  import h4rx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  // Received bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Deframed words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic [4:0]       m_axis_tuser,   // [0] packet_kind, [1] first_flag,
                                           // [2] drop_ok, [4:3] status
  output logic             m_axis_tlast    // last_flag
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_EVT  = 2'd1;
  localparam logic [1:0] PH_ACL  = 2'd2;

  // Configuration
  logic [15:0] payload_limit;
  logic        bredr_enable;

  // Deframer state
  logic [1:0]  phase, phase_next;
  logic [7:0]  hdr [HDR_BYTES];
  logic [7:0]  hdr_next [HDR_BYTES];
  logic [2:0]  hdr_count, hdr_count_next;
  logic [2:0]  hdr_len, hdr_len_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] skip_left, skip_left_next;
  logic        in_payload, in_payload_next;
  logic        discard_mark, discard_mark_next;
  logic        kind, kind_next;

  // Result buffer
  result_t     res [MAX_RESULTS];
  result_t     res_load [MAX_RESULTS];
  logic [2:0]  res_count;
  logic [2:0]  res_rem;
  logic [1:0]  res_ptr;
  result_t     res_head;

  logic        s_fire, m_fire, to_idle;
  logic [7:0]  b;
  logic [15:0] len;

  assign b      = s_axis_tdata;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  // Take a new byte once the buffer empties, or as its last word leaves
  assign s_axis_tready = (res_rem == 3'd0) || ((res_rem == 3'd1) && m_axis_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= 16'd255;
      bredr_enable  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAYLOAD_LIMIT: payload_limit <= cfg_data;
        CFG_BREDR_ENABLE:  bredr_enable  <= cfg_data[0];
        default:           payload_limit <= payload_limit;
      endcase
    end
  end

  // Next state and result set for one received byte
  always_comb begin
    phase_next        = phase;
    hdr_next          = hdr;
    hdr_count_next    = hdr_count;
    hdr_len_next      = hdr_len;
    bytes_left_next   = bytes_left;
    skip_left_next    = skip_left;
    in_payload_next   = in_payload;
    discard_mark_next = discard_mark;
    kind_next         = kind;
    res_count         = 3'd0;
    to_idle           = 1'b0;
    len               = 16'd0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res_load[k] = '0;
    end

    if (skip_left != 16'd0) begin
      // Swallow an oversize payload
      skip_left_next = skip_left - 16'd1;
    end else if (in_payload) begin
      // Forward one payload byte
      bytes_left_next          = bytes_left - 16'd1;
      res_load[0].out_byte     = b;
      res_load[0].packet_kind  = kind;
      res_load[0].last_flag    = (bytes_left_next == 16'd0);
      res_load[0].drop_ok      = discard_mark;
      res_load[0].status       = ST_BYTE;
      res_count                = 3'd1;
      to_idle                  = (bytes_left_next == 16'd0);
    end else if (phase != PH_EVT && phase != PH_ACL) begin
      // Decode the type byte
      to_idle = 1'b1;
      if (b == TYPE_EVT) begin
        to_idle           = 1'b0;
        phase_next        = PH_EVT;
        hdr_count_next    = 3'd0;
        hdr_len_next      = 3'd2;
        bytes_left_next   = 16'd0;
        in_payload_next   = 1'b0;
        discard_mark_next = 1'b0;
        kind_next         = 1'b0;
      end else if (b == TYPE_ACL) begin
        to_idle           = 1'b0;
        phase_next        = PH_ACL;
        hdr_count_next    = 3'd0;
        hdr_len_next      = 3'd4;
        bytes_left_next   = 16'd0;
        in_payload_next   = 1'b0;
        discard_mark_next = 1'b0;
        kind_next         = 1'b1;
      end else begin
        res_load[0].status = ST_BAD_TYPE;
        res_count          = 3'd1;
      end
    end else begin
      // Gather a header byte
      hdr_next[hdr_count[1:0]] = b;
      hdr_count_next           = hdr_count + 3'd1;
      if (phase == PH_EVT && hdr_count_next == 3'd1) begin
        if (b == EVT_LE_META) begin
          hdr_len_next = 3'd3;
        end else if (bredr_enable && (b == EVT_INQ_RSSI || b == EVT_INQ_EXT)) begin
          discard_mark_next = 1'b1;
        end
      end
      if (hdr_count_next >= hdr_len_next) begin
        // Header complete: work out the payload length
        if (phase == PH_EVT) begin
          len = {8'd0, hdr_next[1]};
          if (hdr_len_next == 3'd3) begin
            if (hdr_next[2] == LE_ADV_REPORT) begin
              discard_mark_next = 1'b1;
            end
            len = (hdr_next[1] == 8'd0) ? 16'd0 : {8'd0, hdr_next[1] - 8'd1};
          end
        end else begin
          len = {hdr_next[3], hdr_next[2]};
        end
        if (len > payload_limit) begin
          // Report and skip the oversize payload
          res_load[0].packet_kind = kind;
          res_load[0].status      = ST_OVERSIZE;
          res_count               = 3'd1;
          skip_left_next          = len;
          to_idle                 = 1'b1;
        end else begin
          // Emit the header bytes
          for (int i = 0; i < HDR_BYTES; i++) begin
            if (3'(i) < hdr_len_next) begin
              res_load[i].out_byte    = hdr_next[i];
              res_load[i].packet_kind = kind;
              res_load[i].first_flag  = (i == 0);
              res_load[i].last_flag   = (len == 16'd0) && (3'(i + 1) == hdr_len_next);
              res_load[i].drop_ok     = discard_mark_next;
              res_load[i].status      = ST_BYTE;
            end
          end
          res_count = hdr_len_next;
          if (len == 16'd0) begin
            to_idle = 1'b1;
          end else begin
            in_payload_next = 1'b1;
            bytes_left_next = len;
            hdr_count_next  = 3'd0;
          end
        end
      end
    end

    // Drop back to waiting for a type byte
    if (to_idle) begin
      phase_next        = PH_IDLE;
      hdr_count_next    = 3'd0;
      hdr_len_next      = 3'd0;
      bytes_left_next   = 16'd0;
      in_payload_next   = 1'b0;
      discard_mark_next = 1'b0;
      kind_next         = 1'b0;
    end
  end

  // Advance deframer state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hdr_count    <= 3'd0;
      hdr_len      <= 3'd0;
      bytes_left   <= 16'd0;
      skip_left    <= 16'd0;
      in_payload   <= 1'b0;
      discard_mark <= 1'b0;
      kind         <= 1'b0;
    end else if (s_fire) begin
      phase        <= phase_next;
      hdr_count    <= hdr_count_next;
      hdr_len      <= hdr_len_next;
      bytes_left   <= bytes_left_next;
      skip_left    <= skip_left_next;
      in_payload   <= in_payload_next;
      discard_mark <= discard_mark_next;
      kind         <= kind_next;
    end
  end

  // Header store needs no reset: each byte is written before it is read
  always_ff @(posedge clk) begin
    if (s_fire) begin
      hdr <= hdr_next;
    end
  end

  // Result buffer control: load a fresh set, or step past a taken word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_rem <= 3'd0;
      res_ptr <= 2'd0;
    end else if (s_fire) begin
      res_rem <= res_count;
      res_ptr <= 2'd0;
    end else if (m_fire) begin
      res_rem <= res_rem - 3'd1;
      res_ptr <= res_ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      res <= res_load;
    end
  end

  // Present the current word
  assign res_head      = res[res_ptr];
  assign m_axis_tvalid = (res_rem != 3'd0);
  assign m_axis_tdata  = res_head.out_byte;
  assign m_axis_tlast  = res_head.last_flag;
  assign m_axis_tuser  = {res_head.status, res_head.drop_ok, res_head.first_flag,
                          res_head.packet_kind};

  // Checks
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    res_rem <= 3'(MAX_RESULTS))
    else $error("result buffer count out of range");

  a_skip_not_payload: assert property (@(posedge clk) disable iff (rst)
    (skip_left != 16'd0) |-> !in_payload)
    else $error("skipping while in payload");

  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (phase == PH_EVT || phase == PH_ACL))
    else $error("payload outside a packet phase");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    (s_fire && skip_left != 16'd0) |=> !m_axis_tvalid)
    else $error("word produced while skipping");

  a_last_is_byte: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (res_head.status == ST_BYTE))
    else $error("last flag on a status word");

endmodule

`default_nettype wire
